// ===== hdl/bse_pkg.sv =====
`default_nettype none
package bse_pkg;

    localparam int OFFSET_BITS   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int NUM_BINS      = 256;
    localparam int BIN_W         = $clog2(NUM_BINS);
    localparam int CNT_W         = 32;
    localparam int OUT_W         = 32;
    localparam int ENT_W         = 20;

    // log2 in Q.LOG_FRAC, integer part up to 31
    localparam int LOG_FRAC  = 24;
    localparam int LOG_CNT_W = $clog2(LOG_FRAC);
    localparam int LOG_W     = LOG_FRAC + 5;
    localparam int PROD_W    = CNT_W + LOG_W;
    localparam int SUM_W     = PROD_W + BIN_W;
    localparam int NUM_W     = SUM_W + 1;

    localparam int SHIFT_RAW = LOG_FRAC - FRACTION_BITS;
    localparam int SHIFT     = (SHIFT_RAW < 0) ? 0 : ((SHIFT_RAW > 16) ? 16 : SHIFT_RAW);
    localparam int Q_W       = CNT_W + SHIFT;
    // quotient stays below 2^(LOG_W - SHIFT) plus rounding
    localparam int QUO_W     = LOG_W + 1 - SHIFT;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    localparam longint CAP_RAW = longint'(8) << FRACTION_BITS;
    localparam longint ENT_MAX = (longint'(1) << ENT_W) - 1;
    localparam longint ENT_CAP = (CAP_RAW > ENT_MAX) ? ENT_MAX : CAP_RAW;

    typedef struct packed {
        logic clr_step;
        logic rd_byte;
        logic inc;
        logic sweep_rd;
        logic log_start;
        logic log_sel_n;
        logic mul;
        logic mul_sel_n;
        logic acc;
        logic idx_next;
        logic div_start;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic close;
        logic idx_last;
        logic bin_nz;
        logic log_done;
        logic div_done;
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

// ===== hdl/bse_if.sv =====
`default_nettype none
interface bse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface bse_out_if;
    logic        valid;
    logic        ready;
    logic [19:0] entropy_fixed;
    logic [31:0] block_start;
    logic [31:0] block_end;

    modport source (output valid, output entropy_fixed, output block_start,
                    output block_end, input ready);
    modport sink   (input valid, input entropy_fixed, input block_start,
                    input block_end, output ready);
endinterface
`default_nettype wire

// ===== hdl/block_shannon_entropy_top.sv =====
// Channel | Dir | Payload                                  | Transfer
// i_in    | in  | byte_value[7:0], last_byte               | valid & ready
// o_out   | out | entropy_fixed[19:0], block_start[31:0],  | valid & ready
//         |     | block_end[31:0]                          |
// i_cfg   | in  | i_cfg_data[31:0] (bytes per block)       | i_cfg_we
//
// A byte is taken as one histogram read, then a read-modify-write of the bin.
// A closing block runs a pass over the 256 bins: each bin is read and checked,
// and a nonzero bin also runs the 24-step log2 squaring loop and is weighted;
// then come log2(n), a rounding divide (22 steps) and the output load.
// After reset a pass over all 256 bins clears the histogram before any byte.
// A finished result sits in the output register; the next block's bytes are
// taken while it waits, and only the next result load stalls on it.
`default_nettype none
module block_shannon_entropy_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    bse_in_if.sink            i_in,
    bse_out_if.source         o_out,
    input  wire logic         i_cfg_we,
    input  wire logic [31:0]  i_cfg_data
);

    bse_pkg::t_cmd cmd;
    bse_pkg::t_sts sts;

    bse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bse_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_byte     (i_in.byte_value),
        .i_last     (i_in.last_byte),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_entropy  (o_out.entropy_fixed),
        .o_start    (o_out.block_start),
        .o_end      (o_out.block_end)
    );

    a_one_byte_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while previous byte in flight");

    a_entropy_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (64'(o_out.entropy_fixed) <= 64'(bse_pkg::ENT_CAP)))
        else $error("entropy above cap");

    a_block_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.block_end != o_out.block_start))
        else $error("empty block reported");

endmodule
`default_nettype wire

// ===== hdl/bse_log2.sv =====
`default_nettype none
module bse_log2 (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [bse_pkg::CNT_W-1:0]    i_x,
    output logic                              o_done,
    output logic [bse_pkg::LOG_W-1:0]         o_log
);

    logic                              r_busy;
    logic                              r_done;
    logic [bse_pkg::LOG_CNT_W-1:0]     r_cnt;
    logic [31:0]                       r_y;
    logic [bse_pkg::LOG_W-1:0]         r_log;
    logic [4:0]                        msb;
    logic [63:0]                       sq;
    logic [32:0]                       sq_sh;

    always_comb begin
        msb = '0;
        for (int i = 0; i < 32; i++) begin
            if (i_x[i]) begin
                msb = 5'(i);
            end
        end
    end

    assign sq    = 64'(r_y) * 64'(r_y);
    assign sq_sh = sq[63:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= bse_pkg::LOG_CNT_W'(bse_pkg::LOG_FRAC - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_y   <= 32'(i_x << (5'd31 - msb));
            r_log <= {msb, {bse_pkg::LOG_FRAC{1'b0}}};
        end else if (r_busy) begin
            if (sq_sh[32]) begin
                r_log[r_cnt] <= 1'b1;
                r_y          <= sq_sh[32:1];
            end else begin
                r_y <= sq_sh[31:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_log  = r_log;

endmodule
`default_nettype wire

// ===== hdl/bse_datapath.sv =====
`default_nettype none
module bse_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bse_pkg::t_cmd                i_cmd,
    output bse_pkg::t_sts                     o_sts,
    input  wire logic [7:0]                   i_byte,
    input  wire logic                         i_last,
    input  wire logic                         i_cfg_we,
    input  wire logic [31:0]                  i_cfg_data,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [bse_pkg::ENT_W-1:0]         o_entropy,
    output logic [bse_pkg::OUT_W-1:0]         o_start,
    output logic [bse_pkg::OUT_W-1:0]         o_end
);

    localparam logic [bse_pkg::QUO_W-1:0] CAP_Q = bse_pkg::QUO_W'(bse_pkg::ENT_CAP);

    logic [bse_pkg::CNT_W-1:0]       r_mem [bse_pkg::NUM_BINS];
    logic [bse_pkg::CNT_W-1:0]       r_rdata;
    logic [bse_pkg::BIN_W-1:0]       r_idx;
    logic [bse_pkg::BIN_W-1:0]       r_addr;
    logic                            r_last;
    logic [31:0]                     r_bsize;
    logic [bse_pkg::CNT_W-1:0]       r_bytes;
    logic [bse_pkg::CNT_W-1:0]       r_cval;
    logic [bse_pkg::OFFSET_BITS-1:0] r_start;
    logic [bse_pkg::PROD_W-1:0]      r_prod;
    logic [bse_pkg::SUM_W-1:0]       r_sum;
    logic [bse_pkg::NUM_W-1:0]       r_rem;
    logic [bse_pkg::NUM_W-1:0]       r_dvs;
    logic [bse_pkg::QUO_W-1:0]       r_quo;
    logic [bse_pkg::DIV_CNT_W-1:0]   r_dcnt;
    logic                            r_dbusy;
    logic                            r_ddone;
    logic                            r_ovalid;
    logic [bse_pkg::ENT_W-1:0]       r_entropy;
    logic [bse_pkg::OUT_W-1:0]       r_ostart;
    logic [bse_pkg::OUT_W-1:0]       r_oend;

    logic                            wr_en;
    logic [bse_pkg::BIN_W-1:0]       wr_addr;
    logic [bse_pkg::CNT_W-1:0]       wr_data;
    logic [bse_pkg::BIN_W-1:0]       rd_addr;
    logic                            log_done;
    logic [bse_pkg::LOG_W-1:0]       log_val;
    logic [bse_pkg::CNT_W-1:0]       log_x;
    logic [bse_pkg::CNT_W-1:0]       mul_a;
    logic [bse_pkg::SUM_W-1:0]       diff;
    logic [bse_pkg::Q_W-1:0]         q;
    logic [bse_pkg::NUM_W-1:0]       num;
    logic                            ge;
    logic [bse_pkg::OFFSET_BITS-1:0] blk_end;

    always_comb begin
        wr_en   = i_cmd.clr_step | i_cmd.sweep_rd | i_cmd.inc;
        wr_addr = i_cmd.inc ? r_addr : r_idx;
        wr_data = i_cmd.inc ? r_rdata + 1'b1 : '0;
        rd_addr = i_cmd.rd_byte ? i_byte : r_idx;
    end

    // read returns the old entry when the same address is zeroed
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign log_x = i_cmd.log_sel_n ? r_bytes : r_rdata;
    assign mul_a = i_cmd.mul_sel_n ? r_bytes : r_cval;

    bse_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.log_start),
        .i_x     (log_x),
        .o_done  (log_done),
        .o_log   (log_val)
    );

    assign diff    = (bse_pkg::SUM_W'(r_prod) > r_sum) ? bse_pkg::SUM_W'(r_prod) - r_sum : '0;
    assign q       = {r_bytes, {bse_pkg::SHIFT{1'b0}}};
    assign num     = bse_pkg::NUM_W'(diff) + bse_pkg::NUM_W'(q >> 1);
    assign ge      = r_rem >= r_dvs;
    assign blk_end = r_start + bse_pkg::OFFSET_BITS'(r_bytes);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_byte) begin
            r_addr <= i_byte;
        end
        if (i_cmd.log_start && !i_cmd.log_sel_n) begin
            r_cval <= r_rdata;
        end
        if (i_cmd.mul) begin
            r_prod <= bse_pkg::PROD_W'(mul_a * log_val);
        end
        if (i_cmd.div_start) begin
            r_rem <= num;
            r_dvs <= bse_pkg::NUM_W'(q) << (bse_pkg::QUO_W - 1);
            r_quo <= '0;
        end else if (r_dbusy) begin
            if (ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_dvs <= r_dvs >> 1;
            r_quo <= {r_quo[bse_pkg::QUO_W-2:0], ge};
        end
        if (i_cmd.load_out) begin
            r_entropy <= bse_pkg::ENT_W'((r_quo > CAP_Q) ? CAP_Q : r_quo);
            r_ostart  <= bse_pkg::OUT_W'(r_start);
            r_oend    <= bse_pkg::OUT_W'(blk_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_last   <= 1'b0;
            r_bsize  <= 32'd1;
            r_bytes  <= '0;
            r_start  <= '0;
            r_sum    <= '0;
            r_dbusy  <= 1'b0;
            r_ddone  <= 1'b0;
            r_dcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_ddone <= r_dbusy && !i_cmd.div_start && (r_dcnt == '0);
            if (i_cfg_we) begin
                r_bsize <= i_cfg_data;
            end
            if (i_cmd.clr_step || i_cmd.idx_next) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.rd_byte) begin
                r_last <= i_last;
            end
            if (i_cmd.inc) begin
                r_bytes <= r_bytes + 1'b1;
            end
            if (i_cmd.acc) begin
                r_sum <= r_sum + bse_pkg::SUM_W'(r_prod);
            end
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= bse_pkg::DIV_CNT_W'(bse_pkg::QUO_W - 1);
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt - 1'b1;
                if (r_dcnt == '0) begin
                    r_dbusy <= 1'b0;
                end
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
                r_bytes  <= '0;
                r_sum    <= '0;
                r_last   <= 1'b0;
                r_start  <= r_last ? '0 : blk_end;
            end
        end
    end

    // block size zero acts as one: the compare is then always true
    always_comb begin
        o_sts.close    = ({1'b0, r_bytes} + 1'b1 >= {1'b0, r_bsize}) || r_last;
        o_sts.idx_last = (r_idx == bse_pkg::BIN_W'(bse_pkg::NUM_BINS - 1));
        o_sts.bin_nz   = (r_rdata != '0);
        o_sts.log_done = log_done;
        o_sts.div_done = r_ddone;
        o_sts.out_busy = r_ovalid;
    end

    assign o_valid   = r_ovalid;
    assign o_entropy = r_entropy;
    assign o_start   = r_ostart;
    assign o_end     = r_oend;

endmodule
`default_nettype wire

// ===== hdl/bse_ctrl.sv =====
`default_nettype none
module bse_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire bse_pkg::t_sts   i_sts,
    output bse_pkg::t_cmd        o_cmd
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_INC   = 4'd2;
    localparam logic [3:0] S_SWEEP = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_LOG   = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_NEXT  = 4'd7;
    localparam logic [3:0] S_NLOG  = 4'd8;
    localparam logic [3:0] S_DIFF  = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.rd_byte = 1'b1;
                    n_state       = S_INC;
                end
            end
            S_INC: begin
                o_cmd.inc = 1'b1;
                n_state   = i_sts.close ? S_SWEEP : S_IDLE;
            end
            S_SWEEP: begin
                o_cmd.sweep_rd = 1'b1;
                n_state        = S_CHK;
            end
            S_CHK: begin
                if (i_sts.bin_nz) begin
                    o_cmd.log_start = 1'b1;
                    n_state         = S_LOG;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_LOG: begin
                if (i_sts.log_done) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_NEXT;
            end
            S_NEXT: begin
                o_cmd.idx_next = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.log_start = 1'b1;
                    o_cmd.log_sel_n = 1'b1;
                    n_state         = S_NLOG;
                end else begin
                    n_state = S_SWEEP;
                end
            end
            S_NLOG: begin
                if (i_sts.log_done) begin
                    o_cmd.mul       = 1'b1;
                    o_cmd.mul_sel_n = 1'b1;
                    n_state         = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== dv/block_shannon_entropy_chk.sv =====
`default_nettype none
module block_shannon_entropy_chk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bse_in_if.sink           i_in,
    bse_out_if.sink          o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending,
    output int               o_blocks
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [19:0] entropy_fixed;
        logic [31:0] block_start;
        logic [31:0] block_end;
    } t_block_result;

    logic [31:0]   blk_size;
    logic [31:0]   hist [256];
    logic [31:0]   fill;
    logic [31:0]   start_ofs;
    t_block_result expected_blocks [$];

    // log2 in Q.24, truncated
    function automatic logic [63:0] log2_fix(input logic [31:0] x);
        int          k;
        logic [63:0] mant;
        logic [63:0] r;
        k = 31;
        while (k > 0 && x[k] == 1'b0) k--;
        mant = ({32'd0, x} << (31 - k)) & 64'hFFFF_FFFF;
        r = 64'(k) << 24;
        for (int i = 23; i >= 0; i--) begin
            mant = (mant * mant) >> 31;
            if (mant >= 64'h1_0000_0000) begin
                r[i] = 1'b1;
                mant = mant >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [19:0] entropy_of_hist(input logic [31:0] n);
        logic [63:0] total, sum, d, q, e;
        total = 64'(n) * log2_fix(n);
        sum = 0;
        for (int b = 0; b < 256; b++)
            if (hist[b] != 0) sum += 64'(hist[b]) * log2_fix(hist[b]);
        d = (sum > total) ? 64'd0 : total - sum;
        q = 64'(n) << 8;
        e = (d + q / 2) / q;
        if (e > 64'(bse_pkg::ENT_CAP)) e = 64'(bse_pkg::ENT_CAP);
        return e[19:0];
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_blocks  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blk_size  = 32'd1;
            fill      = 0;
            start_ofs = 0;
            foreach (hist[b]) hist[b] = 0;
        end else begin
            if (i_cfg_we) blk_size = i_cfg_data;
            if (i_in.valid && i_in.ready) begin
                t_block_result r;
                hist[i_in.byte_value]++;
                fill++;
                if (fill >= blk_size || i_in.last_byte) begin
                    r.entropy_fixed = entropy_of_hist(fill);
                    r.block_start   = start_ofs;
                    r.block_end     = start_ofs + fill;
                    expected_blocks = {expected_blocks, r};
                    foreach (hist[b]) hist[b] = 0;
                    start_ofs = i_in.last_byte ? 32'd0 : r.block_end;
                    fill = 0;
                end
            end
            if (o_out.valid && o_out.ready) begin
                t_block_result w;
                o_blocks++;
                if (expected_blocks.size() == 0) begin
                    report("result with none expected, block_start", o_out.block_start,
                           32'd0);
                end else begin
                    w = expected_blocks.pop_front();
                    if (o_out.entropy_fixed !== w.entropy_fixed)
                        report("entropy_fixed", 32'(o_out.entropy_fixed), 32'(w.entropy_fixed));
                    if (o_out.block_start !== w.block_start)
                        report("block_start", o_out.block_start, w.block_start);
                    if (o_out.block_end !== w.block_end)
                        report("block_end", o_out.block_end, w.block_end);
                end
            end
        end
        o_pending = expected_blocks.size();
    end
endmodule
`default_nettype wire

// ===== dv/block_shannon_entropy_top_tb.sv =====
`default_nettype none
module block_shannon_entropy_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;
    int          errors, pending, blocks;
    int          idle_cycles = 0;
    int          bytes_sent = 0;
    logic        hold_off = 1'b0;

    bse_in_if  in_ch();
    bse_out_if out_ch();

    block_shannon_entropy_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    block_shannon_entropy_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.sink),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_blocks(blocks)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.byte_value = '0;
        in_ch.last_byte = 1'b0;
        out_ch.ready = 1'b0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int g;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                out_ch.ready <= 1'b0;
                for (int c = 0; c < 3000; c++) @(posedge i_clk);
                hold_off = 1'b0;
            end
            g = gap_len();
            if (g > 0) begin
                out_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic lst, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.byte_value <= b;
        in_ch.last_byte  <= lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic drain_and_set(input logic [31:0] size);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // the entropy pass of a block may run after its result is queued
        repeat (2000) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= size;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // a stream of len bytes; pattern picks the byte distribution
    task automatic send_stream(input int len, input int pattern, input bit close);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (pattern)
                0: b = 8'h00;
                1: b = 8'(i);
                2: b = 8'($urandom_range(0, 3));
                default: b = 8'($urandom);
            endcase
            send_byte(b, close && (i == len - 1), 1'b1);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset size of 1, extremes of byte values
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hA5, 1'b1, 1'b0);
        drain_and_set(32'd0);               // zero acts as one
        send_byte(8'h5A, 1'b0, 1'b1);
        send_byte(8'h01, 1'b1, 1'b1);
        drain_and_set(32'd4);
        send_stream(4, 0, 1'b0);            // all equal: zero entropy
        send_stream(4, 1, 1'b0);            // all distinct: 2 bits
        send_stream(3, 3, 1'b1);            // short final block
        drain_and_set(32'd256);
        send_stream(256, 1, 1'b1);          // uniform: full 8 bits

        // large size: only last_byte ever closes
        drain_and_set(32'hFFFF_FFFF);
        send_stream(40, 3, 1'b1);
        send_stream(1, 3, 1'b1);

        // random phases over several sizes
        for (int ph = 0; ph < 6; ph++) begin
            drain_and_set(32'($urandom_range(1, 20)));
            for (int s = 0; s < 6; s++)
                send_stream($urandom_range(1, 40), $urandom_range(0, 3),
                            $urandom_range(0, 3) != 0);
        end

        // back pressure: receiver stalls while bytes keep coming
        drain_and_set(32'd1);
        hold_off = 1'b1;
        send_stream(60, 3, 1'b0);
        send_stream(4, 3, 1'b1);

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);

        $display("run: %0d bytes in, %0d entropy blocks checked, sizes 0..2^32-1",
                 bytes_sent, blocks);
        if (errors == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/bse_pkg.sv
hdl/bse_if.sv
hdl/bse_log2.sv
hdl/bse_datapath.sv
hdl/bse_ctrl.sv
hdl/block_shannon_entropy_top.sv
dv/block_shannon_entropy_chk.sv
dv/block_shannon_entropy_top_tb.sv
